/* rtl/core/pdve_pkg.sv */
// Shared types, command records, constants and tables for the pose-delta velocity estimator.
`timescale 1ns / 1ps

package pdve_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC1,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MAC2,
    S_DONE
  } pdve_state_t;

  typedef enum logic [3:0] {
    OP_QX,
    OP_QY,
    OP_QZ,
    OP_QW,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_A0,
    OP_A1,
    OP_A2,
    OP_DIST,
    OP_DYAW,
    OP_KSPD,
    OP_KYAW
  } opsel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_N2,
    DST_M00,
    DST_M10,
    DST_M20,
    DST_SSQ,
    DST_DOT,
    DST_SPN,
    DST_YWN
  } mac_dst_t;

  typedef enum logic [2:0] {
    DIV_AX0,
    DIV_AX1,
    DIV_AX2,
    DIV_SPD,
    DIV_YAW
  } div_sel_t;

  typedef struct packed {
    opsel_t   a;
    opsel_t   b;
    logic     neg;
    logic     first;
    mac_dst_t dst;
  } mac_op_t;

  typedef struct packed {
    logic       load;
    logic       mac_en;
    logic [4:0] mac_idx;
    logic       root_start;
    logic       div_start;
    logic       div_take;
    div_sel_t   div_sel;
    logic       finish;
  } pdve_cmd_t;

  typedef struct packed {
    logic sq_busy;
    logic cordic_busy;
    logic div_busy;
    logic out_free;
  } pdve_stat_t;

  localparam int MAC_STEPS = 20;
  localparam logic [4:0] MAC1_FIRST = 5'd0;
  localparam logic [4:0] MAC1_LAST  = 5'd17;
  localparam logic [4:0] MAC2_FIRST = 5'd18;
  localparam logic [4:0] MAC2_LAST  = 5'd19;

  // Multiply-accumulate program: quaternion terms, squared distance, heading dot
  // product, then the two rate numerators once root and yaw are known.
  localparam mac_op_t MAC_TABLE [MAC_STEPS] = '{
    '{OP_QX,   OP_QX,   1'b0, 1'b1, DST_NONE},
    '{OP_QY,   OP_QY,   1'b0, 1'b0, DST_NONE},
    '{OP_QZ,   OP_QZ,   1'b0, 1'b0, DST_NONE},
    '{OP_QW,   OP_QW,   1'b0, 1'b0, DST_N2},
    '{OP_QW,   OP_QW,   1'b0, 1'b1, DST_NONE},
    '{OP_QX,   OP_QX,   1'b0, 1'b0, DST_NONE},
    '{OP_QY,   OP_QY,   1'b1, 1'b0, DST_NONE},
    '{OP_QZ,   OP_QZ,   1'b1, 1'b0, DST_M00},
    '{OP_QX,   OP_QY,   1'b0, 1'b1, DST_NONE},
    '{OP_QW,   OP_QZ,   1'b0, 1'b0, DST_M10},
    '{OP_QX,   OP_QZ,   1'b0, 1'b1, DST_NONE},
    '{OP_QW,   OP_QY,   1'b1, 1'b0, DST_M20},
    '{OP_D0,   OP_D0,   1'b0, 1'b1, DST_NONE},
    '{OP_D1,   OP_D1,   1'b0, 1'b0, DST_NONE},
    '{OP_D2,   OP_D2,   1'b0, 1'b0, DST_SSQ},
    '{OP_D0,   OP_A0,   1'b0, 1'b1, DST_NONE},
    '{OP_D1,   OP_A1,   1'b0, 1'b0, DST_NONE},
    '{OP_D2,   OP_A2,   1'b0, 1'b0, DST_DOT},
    '{OP_DIST, OP_KSPD, 1'b0, 1'b1, DST_SPN},
    '{OP_DYAW, OP_KYAW, 1'b0, 1'b1, DST_YWN}
  };

  localparam int NUM_W = 72;
  localparam int DEN_W = 63;
  localparam int QUO_W = 32;

  localparam logic [QUO_W-1:0] QUO_SAT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [4:0] AXIS_MSB = 5'd14;
  localparam logic [4:0] RATE_MSB = 5'd30;

  // 65536e6 = 1e6 << 16 and 8e9 = 1953125 << 12.
  localparam logic signed [33:0] K_SPD = 34'sd1000000;
  localparam logic signed [33:0] K_YAW = 34'sd1953125;

  localparam logic signed [15:0] AXIS_ONE   = 16'sd16384;
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam int ATAN_COUNT = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_COUNT] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

endpackage

/* rtl/core/pdve_div.sv */
// Restoring radix-2 divider with a cap at 2^31, one quotient bit per cycle.
`timescale 1ns / 1ps

module pdve_div import pdve_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [4:0]       msb,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [4:0]       bit_idx;
  logic [93:0]      trial;
  logic             sat;

  assign trial = {31'b0, dsr} << bit_idx;
  assign sat   = {22'b0, num} >= {den, 31'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !sat;
    end else if (busy && bit_idx == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num;
      dsr     <= den;
      bit_idx <= msb;
      quo     <= sat ? QUO_SAT : '0;
    end else if (busy) begin
      if ({22'b0, rem} >= trial) begin
        rem          <= rem - trial[NUM_W-1:0];
        quo[bit_idx] <= 1'b1;
      end
      if (bit_idx != 5'd0) begin
        bit_idx <= bit_idx - 5'd1;
      end
    end
  end

endmodule

/* rtl/core/pdve_cordic.sv */
// Vectoring CORDIC that returns atan2(y, x) as a Q2.13 angle, one rotation per cycle.
`timescale 1ns / 1ps

module pdve_cordic import pdve_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] x0,
  input  logic signed [34:0] y0,
  output logic               busy,
  output logic signed [15:0] yaw
);

  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic signed [37:0] x, y, xe, ye, xs, ys;
  logic signed [33:0] z, zr, at;
  logic [4:0]         i;

  assign xe = 38'(x0);
  assign ye = 38'(y0);
  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = signed'({2'b0, ATAN_Q30[i]});
  assign zr = z + 34'sd65536;
  assign yaw = zr[32:17];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && i == LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i <= '0;
      // Vectors in the left half plane are turned by a quarter first.
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x <= ye;
          y <= -xe;
          z <= HALF_PI_Q30;
        end else begin
          x <= -ye;
          y <= xe;
          z <= -HALF_PI_Q30;
        end
      end else begin
        x <= xe;
        y <= ye;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
      i <= i + 5'd1;
    end
  end

endmodule

/* rtl/core/pdve_dp.sv */
// Datapath: kept pose, shared multiply-accumulate, square root, CORDIC, divider and output register.
`timescale 1ns / 1ps

module pdve_dp import pdve_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pdve_cmd_t          cmd,
  output pdve_stat_t         stat,
  input  logic [62:0]        stamp_ns,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] speed,
  output logic signed [31:0] yaw_rate
);

  // Current beat.
  logic [62:0]        cur_stamp;
  logic signed [31:0] cur_pos [3];
  logic signed [15:0] cur_q [4];

  // Kept pose.
  logic [62:0]        last_stamp;
  logic signed [31:0] last_pos [3];
  logic signed [15:0] last_yaw;
  logic signed [15:0] last_axis [3];

  // Intermediate results.
  logic [32:0]        n2;
  logic signed [34:0] m00;
  logic signed [33:0] m10h, m20h;
  logic [67:0]        ssq;
  logic               dot_neg;
  logic [52:0]        spn;
  logic [37:0]        ywn;
  logic signed [15:0] axis_new [3];
  logic               yaw_ok;
  logic [QUO_W-1:0]   q_spd, q_yaw;

  logic signed [69:0] acc, acc_next, acc_base;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  mac_op_t            op;

  logic signed [32:0] d [3];
  logic [62:0]        dt;
  logic               advanced;

  // Square root state.
  logic        sq_busy;
  logic [71:0] sq_rad;
  logic [39:0] sq_rem, sq_rem_sh, sq_trial;
  logic [35:0] sq_root;
  logic [5:0]  sq_cnt;
  logic [32:0] dist_mm;

  logic               cordic_busy;
  logic signed [15:0] cyaw, yaw_new;
  logic signed [17:0] dyaw0, dyaw1, dyaw;
  logic [16:0]        dyaw_mag;
  logic signed [34:0] m10, m20;

  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [4:0]         div_msb;
  logic               div_busy;
  logic [QUO_W-1:0]   div_quo;
  logic signed [15:0] axis_q;

  function automatic logic [34:0] mag35(input logic signed [34:0] v);
    return v[34] ? 35'(-v) : 35'(v);
  endfunction

  function automatic logic [31:0] sign_out(input logic [QUO_W-1:0] mag, input logic neg);
    if (neg) begin
      return ~mag + 32'd1;
    end
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

  function automatic logic signed [33:0] opnd(input opsel_t s);
    unique case (s)
      OP_QX:   return 34'(cur_q[0]);
      OP_QY:   return 34'(cur_q[1]);
      OP_QZ:   return 34'(cur_q[2]);
      OP_QW:   return 34'(cur_q[3]);
      OP_D0:   return 34'(d[0]);
      OP_D1:   return 34'(d[1]);
      OP_D2:   return 34'(d[2]);
      OP_A0:   return 34'(last_axis[0]);
      OP_A1:   return 34'(last_axis[1]);
      OP_A2:   return 34'(last_axis[2]);
      OP_DIST: return signed'({1'b0, dist_mm});
      OP_DYAW: return signed'({17'b0, dyaw_mag});
      OP_KSPD: return K_SPD;
      OP_KYAW: return K_YAW;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = 33'(cur_pos[k]) - 33'(last_pos[k]);
    end
  end

  assign dt       = cur_stamp - last_stamp;
  assign advanced = cur_stamp > last_stamp;

  // Shared multiplier and accumulator.
  assign op       = MAC_TABLE[cmd.mac_idx];
  assign mul_a    = opnd(op.a);
  assign mul_b    = opnd(op.b);
  assign prod     = mul_a * mul_b;
  assign acc_base = op.first ? '0 : acc;
  assign acc_next = op.neg ? acc_base - 70'(prod) : acc_base + 70'(prod);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_stamp  <= stamp_ns;
      cur_pos[0] <= pos_x;
      cur_pos[1] <= pos_y;
      cur_pos[2] <= pos_z;
      cur_q[0]   <= quat_x;
      cur_q[1]   <= quat_y;
      cur_q[2]   <= quat_z;
      cur_q[3]   <= quat_w;
    end
    if (cmd.mac_en) begin
      acc <= acc_next;
      unique case (op.dst)
        DST_NONE: ;
        DST_N2:   n2      <= acc_next[32:0];
        DST_M00:  m00     <= acc_next[34:0];
        DST_M10:  m10h    <= acc_next[33:0];
        DST_M20:  m20h    <= acc_next[33:0];
        DST_SSQ:  ssq     <= acc_next[67:0];
        DST_DOT:  dot_neg <= acc_next[69];
        DST_SPN:  spn     <= acc_next[52:0];
        DST_YWN:  ywn     <= acc_next[37:0];
        default:  ;
      endcase
    end
  end

  assign m10 = {m10h, 1'b0};
  assign m20 = {m20h, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      // Yaw is defined only away from the zero quaternion and gimbal lock.
      yaw_ok <= (n2 != '0) && ({2'b0, n2} > {2'b0, mag35(m20)});
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  assign sq_rem_sh = {sq_rem[37:0], sq_rad[71:70]};
  assign sq_trial  = {2'b0, sq_root, 2'b01};
  assign dist_mm   = sq_root[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.root_start) begin
      sq_busy <= 1'b1;
    end else if (sq_busy && sq_cnt == 6'd35) begin
      sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      sq_rad  <= {4'b0, ssq};
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= '0;
    end else if (sq_busy) begin
      sq_rad <= {sq_rad[69:0], 2'b00};
      sq_cnt <= sq_cnt + 6'd1;
      if (sq_rem_sh >= sq_trial) begin
        sq_rem  <= sq_rem_sh - sq_trial;
        sq_root <= {sq_root[34:0], 1'b1};
      end else begin
        sq_rem  <= sq_rem_sh;
        sq_root <= {sq_root[34:0], 1'b0};
      end
    end
  end

  pdve_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .x0    (m00),
    .y0    (m10),
    .busy  (cordic_busy),
    .yaw   (cyaw)
  );

  assign yaw_new = yaw_ok ? cyaw : 16'sd0;
  assign dyaw0   = 18'(yaw_new) - 18'(last_yaw);
  assign dyaw1   = (dyaw0 > PI_Q13) ? dyaw0 - TWO_PI_Q13 : dyaw0;
  assign dyaw    = (dyaw1 < -PI_Q13) ? dyaw1 + TWO_PI_Q13 : dyaw1;
  assign dyaw_mag = dyaw[17] ? 17'(-dyaw) : dyaw[16:0];

  always_comb begin
    div_num = '0;
    div_den = {30'b0, n2};
    div_msb = AXIS_MSB;
    unique case (cmd.div_sel)
      DIV_AX0: div_num = {23'b0, mag35(m00), 14'b0};
      DIV_AX1: div_num = {23'b0, mag35(m10), 14'b0};
      DIV_AX2: div_num = {23'b0, mag35(m20), 14'b0};
      DIV_SPD: begin
        div_num = {3'b0, spn, 16'b0};
        div_den = dt;
        div_msb = RATE_MSB;
      end
      DIV_YAW: begin
        div_num = {22'b0, ywn, 12'b0};
        div_den = dt;
        div_msb = RATE_MSB;
      end
      default: ;
    endcase
  end

  pdve_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .msb   (div_msb),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign axis_q = signed'(div_quo[15:0]);

  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      unique case (cmd.div_sel)
        DIV_AX0: axis_new[0] <= (n2 == '0) ? AXIS_ONE : (m00[34] ? -axis_q : axis_q);
        DIV_AX1: axis_new[1] <= (n2 == '0) ? 16'sd0 : (m10[34] ? -axis_q : axis_q);
        DIV_AX2: axis_new[2] <= (n2 == '0) ? 16'sd0 : (m20[34] ? -axis_q : axis_q);
        DIV_SPD: q_spd <= div_quo;
        DIV_YAW: q_yaw <= div_quo;
        default: ;
      endcase
    end
  end

  // Kept pose is replaced when the result is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp   <= '0;
      last_pos[0]  <= '0;
      last_pos[1]  <= '0;
      last_pos[2]  <= '0;
      last_yaw     <= '0;
      last_axis[0] <= AXIS_ONE;
      last_axis[1] <= '0;
      last_axis[2] <= '0;
    end else if (cmd.finish) begin
      last_stamp   <= cur_stamp;
      last_pos[0]  <= cur_pos[0];
      last_pos[1]  <= cur_pos[1];
      last_pos[2]  <= cur_pos[2];
      last_yaw     <= yaw_new;
      last_axis[0] <= axis_new[0];
      last_axis[1] <= axis_new[1];
      last_axis[2] <= axis_new[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      speed    <= advanced ? signed'(sign_out(q_spd, dot_neg)) : 32'sd0;
      yaw_rate <= advanced ? signed'(sign_out(q_yaw, dyaw[17])) : 32'sd0;
    end
  end

  assign stat.sq_busy     = sq_busy;
  assign stat.cordic_busy = cordic_busy;
  assign stat.div_busy    = div_busy;
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

/* rtl/core/pdve_ctrl.sv */
// Controller state machine that sequences the datapath for one beat at a time.
`timescale 1ns / 1ps

module pdve_ctrl import pdve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  pdve_stat_t stat,
  output pdve_cmd_t  cmd
);

  pdve_state_t state, state_next;
  logic [4:0]  step;
  div_sel_t    dsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= MAC1_FIRST;
      dsel <= DIV_AX0;
    end else begin
      if (cmd.load) begin
        step <= MAC1_FIRST;
        dsel <= DIV_AX0;
      end else if (cmd.mac_en) begin
        step <= step + 5'd1;
      end
      if (cmd.div_take) begin
        unique case (dsel)
          DIV_AX0: dsel <= DIV_AX1;
          DIV_AX1: dsel <= DIV_AX2;
          DIV_AX2: dsel <= DIV_SPD;
          DIV_SPD: dsel <= DIV_YAW;
          DIV_YAW: dsel <= DIV_YAW;
          default: dsel <= DIV_AX0;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_MAC1;
      S_MAC1:      if (step == MAC1_LAST) state_next = S_ROOT_GO;
      S_ROOT_GO:   state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: if (!stat.sq_busy && !stat.cordic_busy) state_next = S_DIV_GO;
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          priority case (dsel)
            DIV_AX2: state_next = S_MAC2;
            DIV_YAW: state_next = S_DONE;
            default: state_next = S_DIV_GO;
          endcase
        end
      end
      S_MAC2:      if (step == MAC2_LAST) state_next = S_DIV_GO;
      S_DONE:      if (stat.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mac_idx = step;
    cmd.div_sel = dsel;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_MAC1, S_MAC2: cmd.mac_en = 1'b1;
      S_ROOT_GO:      cmd.root_start = 1'b1;
      S_ROOT_WAIT:    ;
      S_DIV_GO:       cmd.div_start = 1'b1;
      S_DIV_WAIT:     cmd.div_take = !stat.div_busy;
      S_DONE:         cmd.finish = stat.out_free;
      default:        ;
    endcase
  end

`ifndef SYNTH
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result handed over while the output register is still held");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_root_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |-> (!stat.sq_busy && !stat.cordic_busy))
    else $error("root or CORDIC started while busy");

  a_load_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input not stalled after a beat was taken");
`endif

endmodule

/* rtl/core/pose_delta_velocity_estimator_core.sv */
// Top level of the pose-delta velocity estimator: controller plus datapath.
`timescale 1ns / 1ps

// Takes one timestamped pose per beat and returns one beat of forward speed and yaw rate,
// both Q16.16 and saturated, measured against the pose kept from the previous beat (reset
// pose for the first one). One beat is worked on at a time: the next beat is taken once the
// result has been handed to the output register. A beat runs through the first part of the
// 20-step shared multiply-accumulate, the square root (the CORDIC runs alongside it), the
// shared radix-2 divider for each of the three axis components, the rest of the shared
// multiply-accumulate, and the divider for each of the two rates; a division that
// saturates ends early. A finished result waits in the output register; the next beat is
// taken meanwhile.
module pose_delta_velocity_estimator_core import pdve_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [62:0]        stamp_ns,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] speed,
  output logic signed [31:0] yaw_rate
);

  pdve_cmd_t  cmd;
  pdve_stat_t stat;

  pdve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdve_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .stamp_ns  (stamp_ns),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .speed     (speed),
    .yaw_rate  (yaw_rate)
  );

endmodule
